// ===== rtl/trimmed_mean_sampler_core_macros.svh =====
// Assertion macros shared by the trimmed mean sampler RTL.
`ifndef TRIMMED_MEAN_SAMPLER_CORE_MACROS_SVH
`define TRIMMED_MEAN_SAMPLER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TMS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("trimmed mean sampler: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("trimmed mean sampler: next-cycle check failed");

`endif

// ===== rtl/tms_pkg.sv =====
// Types and constants of the trimmed mean sampler.
`timescale 1ns / 1ps

package tms_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ERR_W    = 2;

    // Result error codes.
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_SHORT = 2'd1;
    localparam logic [ERR_W-1:0] ERR_LONG  = 2'd2;

    // One input transfer.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last_sample;
    } t_in;

    // One result transfer.
    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic [ERR_W-1:0]    error_code;
    } t_out;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MIN,
        S_MAX,
        S_ADD,
        S_TRIM1,
        S_TRIM2,
        S_DSET,
        S_DIV,
        S_DONE
    } t_state;

    // Operations of the shared adder.
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

// ===== rtl/trimmed_mean_sampler_core.sv =====
// Trimmed mean sampler: drops one minimum and one maximum and averages the rest.
`timescale 1ns / 1ps
// Usage:
// Samples enter one per transfer on i_item, taken at a rising edge where start
// is high and busy is low. last_sample marks the final sample of a group.
// After each transfer busy stays high through the min, max and add steps, so
// a new sample cannot be taken before the last one is through. A group of
// three or more samples (and no more than MAX_SAMPLES) ends with the trimmed
// sum and a restoring division that yields one quotient bit per cycle,
// 16 + clog2(MAX_SAMPLES + 1) bits in all; the result shows in the final busy
// cycle. A short or long group reports its error code with an average of 0
// once its last sample is through the min, max and add steps.
// The min/max compares, sums, trims and division steps run through one shared adder/subtractor under the sequencer.
// o_result is valid for exactly one cycle while o_strobe is high; the receiver
// cannot stall it and must take it in that cycle.
// A synchronous active-low reset returns the sequencer to idle and clears the
// running minimum, maximum, sum and count; no result is pending after reset.

`include "trimmed_mean_sampler_core_macros.svh"

module trimmed_mean_sampler_core #(
    parameter int MAX_SAMPLES = 255
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  tms_pkg::t_in  i_item,
    output logic          o_strobe,
    output tms_pkg::t_out o_result
);

    import tms_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 2);
    localparam int SUM_W  = SAMPLE_W + $clog2(MAX_SAMPLES + 1);
    localparam int ALU_W  = SUM_W + 1;
    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_SAMPLES);
    localparam logic [CNT_W-1:0]  CNT_MIN   = CNT_W'(3);
    localparam logic [CNT_W-1:0]  CNT_TRIM  = CNT_W'(2);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    t_state              r_state, n_state;
    logic [SAMPLE_W-1:0] r_sample, n_sample;
    logic                r_last, n_last;
    logic                r_take, n_take;
    logic [SAMPLE_W-1:0] r_min, n_min;
    logic [SAMPLE_W-1:0] r_max, n_max;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_div, n_div;
    logic [CNT_W-1:0]    r_rem, n_rem;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [SAMPLE_W-1:0] r_avg, n_avg;
    logic [ERR_W-1:0]    r_err, n_err;

    logic [ALU_W-1:0]    alu_a, alu_b, alu_y;
    logic                alu_borrow;
    t_alu_op             alu_op;
    logic [CNT_W:0]      rem_sh;
    logic [CNT_W-1:0]    cnt_upd;
    logic                q_bit;
    logic [SUM_W-1:0]    q_next;
    logic                accept;

    assign accept = start && !busy;

    // Count after this sample, saturating one above the group limit.
    assign cnt_upd = (r_count <= CNT_MAX) ? r_count + CNT_W'(1) : r_count;

    // Remainder shifted left with the next dividend bit.
    assign rem_sh = {r_rem, r_sum[SUM_W-1]};

    // Shared adder/subtractor; the top bit is the borrow of a subtraction.
    assign alu_y      = (alu_op == ALU_ADD) ? alu_a + alu_b : alu_a - alu_b;
    assign alu_borrow = alu_y[ALU_W-1];

    // Division step: a quotient bit is set when the subtraction does not borrow.
    assign q_bit  = !alu_borrow;
    assign q_next = {r_sum[SUM_W-2:0], q_bit};

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_MIN;
                end
            end
            S_MIN:   n_state = S_MAX;
            S_MAX:   n_state = S_ADD;
            S_ADD: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if ((cnt_upd > CNT_MAX) || (cnt_upd < CNT_MIN)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_TRIM1;
                end
            end
            S_TRIM1: n_state = S_TRIM2;
            S_TRIM2: n_state = S_DSET;
            S_DSET:  n_state = S_DIV;
            S_DIV: begin
                if (r_step == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and operand selection for the shared adder.
    always_comb begin
        busy     = 1'b1;
        o_strobe = 1'b0;
        alu_op   = ALU_SUB;
        alu_a    = '0;
        alu_b    = '0;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
            end
            S_MIN: begin
                alu_a = ALU_W'(r_sample);
                alu_b = ALU_W'(r_min);
            end
            S_MAX: begin
                alu_a = ALU_W'(r_max);
                alu_b = ALU_W'(r_sample);
            end
            S_ADD: begin
                alu_op = ALU_ADD;
                alu_a  = ALU_W'(r_sum);
                alu_b  = ALU_W'(r_sample);
            end
            S_TRIM1: begin
                alu_a = ALU_W'(r_sum);
                alu_b = ALU_W'(r_min);
            end
            S_TRIM2: begin
                alu_a = ALU_W'(r_sum);
                alu_b = ALU_W'(r_max);
            end
            S_DSET: begin
                alu_a = ALU_W'(r_count);
                alu_b = ALU_W'(CNT_TRIM);
            end
            S_DIV: begin
                alu_a = ALU_W'(rem_sh);
                alu_b = ALU_W'(r_div);
            end
            S_DONE: begin
                o_strobe = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // Datapath updates for each sequencer step.
    always_comb begin
        n_sample = r_sample;
        n_last   = r_last;
        n_take   = r_take;
        n_min    = r_min;
        n_max    = r_max;
        n_sum    = r_sum;
        n_count  = r_count;
        n_div    = r_div;
        n_rem    = r_rem;
        n_step   = r_step;
        n_avg    = r_avg;
        n_err    = r_err;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_sample = i_item.sample;
                    n_last   = i_item.last_sample;
                    n_take   = (r_count < CNT_MAX);
                end
            end
            S_MIN: begin
                if (r_take) begin
                    if (r_count == '0) begin
                        n_min = r_sample;
                        n_max = r_sample;
                    end else if (alu_borrow) begin
                        n_min = r_sample;
                    end
                end
            end
            S_MAX: begin
                if (r_take && (r_count != '0) && alu_borrow) begin
                    n_max = r_sample;
                end
            end
            S_ADD: begin
                if (r_take) begin
                    n_sum = alu_y[SUM_W-1:0];
                end
                n_count = cnt_upd;
                if (cnt_upd > CNT_MAX) begin
                    n_err = ERR_LONG;
                    n_avg = '0;
                end else if (cnt_upd < CNT_MIN) begin
                    n_err = ERR_SHORT;
                    n_avg = '0;
                end else begin
                    n_err = ERR_OK;
                end
            end
            S_TRIM1, S_TRIM2: begin
                n_sum = alu_y[SUM_W-1:0];
            end
            S_DSET: begin
                n_div  = alu_y[CNT_W-1:0];
                n_rem  = '0;
                n_step = LAST_STEP;
            end
            S_DIV: begin
                n_rem  = q_bit ? alu_y[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                n_sum  = q_next;
                n_step = r_step - STEP_W'(1);
                if (r_step == '0) begin
                    n_avg = q_next[SAMPLE_W-1:0];
                end
            end
            S_DONE: begin
                n_min   = '0;
                n_max   = '0;
                n_sum   = '0;
                n_count = '0;
            end
            default: begin
                n_step = r_step;
            end
        endcase
    end

    // Control and group state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_min   <= '0;
            r_max   <= '0;
            r_sum   <= '0;
            r_count <= '0;
            r_take  <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_min   <= n_min;
            r_max   <= n_max;
            r_sum   <= n_sum;
            r_count <= n_count;
            r_take  <= n_take;
            r_last  <= n_last;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_step   <= n_step;
        r_avg    <= n_avg;
        r_err    <= n_err;
    end

    assign o_result.average    = r_avg;
    assign o_result.error_code = r_err;

    // Checks on the sequencer and the result.
    `TMS_ASSERT_NEXT(a_accept_busy, accept, busy)
    `TMS_ASSERT_NEXT(a_strobe_single, o_strobe, !o_strobe && !busy)
    `TMS_ASSERT_IMPL(a_error_zero, o_strobe && (o_result.error_code != ERR_OK), o_result.average == '0)
    `TMS_ASSERT_IMPL(a_err_code, o_strobe, (r_err == ERR_OK) || (r_err == ERR_SHORT) || (r_err == ERR_LONG))
    `TMS_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CNT_MAX + CNT_W'(1))

endmodule
